@@ rtl/core/vba_pkg.sv @@
`timescale 1ns / 1ps

package vba_pkg;

   localparam int MAX_DIM    = 64;
   localparam int DIM_W      = $clog2(MAX_DIM + 1);
   localparam int POS_W      = $clog2(MAX_DIM);
   localparam int SLAB_DEPTH = 4096;
   localparam int SLAB_AW    = $clog2(SLAB_DEPTH);
   localparam int SUM_W      = 50;
   localparam int SAMPLE_W   = 32;
   localparam int INDEX_W    = 18;
   localparam int VOL_W      = 3 * POS_W + 1;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_FINE_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FINE_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FINE_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MERGE_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MERGE_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MERGE_Z = 3'd5;

   typedef struct packed {
      logic               ready;
      logic               in_box;
      logic               first;
      logic               last;
      logic               last_cell;
      logic [SLAB_AW-1:0] addr;
      logic [INDEX_W-1:0] index;
      logic [VOL_W-1:0]   vol;
   } geom_type;

endpackage

@@ rtl/core/vba_if.sv @@
`timescale 1ns / 1ps

interface vba_req_if;
   import vba_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] fine_sample;

   modport source (output valid, output fine_sample, input ready);
   modport sink (input valid, input fine_sample, output ready);
endinterface

interface vba_rsp_if;
   import vba_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] coarse_value;
   logic [INDEX_W-1:0]         coarse_index;
   logic                       last_cell;

   modport source (output valid, output coarse_value, output coarse_index,
                   output last_cell, input ready);
   modport sink (input valid, input coarse_value, input coarse_index,
                 input last_cell, output ready);
endinterface

@@ rtl/core/vba_ram.sv @@
`timescale 1ns / 1ps

module vba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/vba_geom.sv @@
`timescale 1ns / 1ps

module vba_geom
   import vba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   input  logic                 advance,
   output geom_type             geom
);

   localparam int LANES = 6;

   typedef enum logic [2:0] {G_LOAD, G_DIV, G_VOL1, G_VOL2, G_RUN} state_type;

   state_type state_ff;

   logic [DIM_W-1:0] fine_x_ff, fine_y_ff, fine_z_ff;
   logic [DIM_W-1:0] merge_x_ff, merge_y_ff, merge_z_ff;
   logic [POS_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [POS_W-1:0] cx_ff, cy_ff, cz_ff;
   logic [POS_W-1:0] rx_ff, ry_ff, rz_ff;
   logic [DIM_W-1:0] nx_ff, ny_ff, nz_ff;
   logic [2*DIM_W-1:0] nynz_ff;
   logic [VOL_W-1:0] vol_ff;
   logic [2:0]       step_ff;

   logic [DIM_W-1:0] lane_q_ff [LANES];
   logic [POS_W-1:0] lane_r_ff [LANES];
   logic [DIM_W-1:0] lane_q_in [LANES];
   logic [POS_W-1:0] lane_r_in [LANES];
   logic [DIM_W-1:0] lane_dvs  [LANES];

   function automatic logic [DIM_W-1:0] eff(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // One restoring division step per cycle in each lane.
   always_comb begin
      lane_dvs[0] = merge_x_ff;
      lane_dvs[1] = merge_y_ff;
      lane_dvs[2] = merge_z_ff;
      lane_dvs[3] = merge_x_ff;
      lane_dvs[4] = merge_y_ff;
      lane_dvs[5] = merge_z_ff;
      for (int i = 0; i < LANES; i++) begin
         logic [DIM_W-1:0] trial;
         logic             ge;
         trial = {lane_r_ff[i], lane_q_ff[i][DIM_W-1]};
         ge = (trial >= lane_dvs[i]);
         lane_r_in[i] = ge ? POS_W'(trial - lane_dvs[i]) : POS_W'(trial);
         lane_q_in[i] = {lane_q_ff[i][DIM_W-2:0], ge};
      end
   end

   logic z_wrap, y_wrap, x_wrap;
   logic z_cell, y_cell, x_cell;

   assign z_wrap = ({1'b0, pos_z_ff} + DIM_W'(1)) >= fine_z_ff;
   assign y_wrap = ({1'b0, pos_y_ff} + DIM_W'(1)) >= fine_y_ff;
   assign x_wrap = ({1'b0, pos_x_ff} + DIM_W'(1)) >= fine_x_ff;
   assign z_cell = ({1'b0, rz_ff} + DIM_W'(1)) == merge_z_ff;
   assign y_cell = ({1'b0, ry_ff} + DIM_W'(1)) == merge_y_ff;
   assign x_cell = ({1'b0, rx_ff} + DIM_W'(1)) == merge_x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= G_LOAD;
         fine_x_ff  <= DIM_W'(1);
         fine_y_ff  <= DIM_W'(1);
         fine_z_ff  <= DIM_W'(1);
         merge_x_ff <= DIM_W'(1);
         merge_y_ff <= DIM_W'(1);
         merge_z_ff <= DIM_W'(1);
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         pos_z_ff   <= '0;
         step_ff    <= '0;
      end else begin
         if (csr_we) begin
            // Any write invalidates the derived geometry.
            state_ff <= G_LOAD;
            unique case (csr_index)
               CSR_FINE_X:  fine_x_ff  <= eff(csr_wdata);
               CSR_FINE_Y:  fine_y_ff  <= eff(csr_wdata);
               CSR_FINE_Z:  fine_z_ff  <= eff(csr_wdata);
               CSR_MERGE_X: merge_x_ff <= eff(csr_wdata);
               CSR_MERGE_Y: merge_y_ff <= eff(csr_wdata);
               CSR_MERGE_Z: merge_z_ff <= eff(csr_wdata);
               default: ;
            endcase
         end else begin
            unique case (state_ff)
               G_LOAD: begin
                  lane_q_ff[0] <= {1'b0, pos_x_ff};
                  lane_q_ff[1] <= {1'b0, pos_y_ff};
                  lane_q_ff[2] <= {1'b0, pos_z_ff};
                  lane_q_ff[3] <= fine_x_ff;
                  lane_q_ff[4] <= fine_y_ff;
                  lane_q_ff[5] <= fine_z_ff;
                  for (int i = 0; i < LANES; i++) begin
                     lane_r_ff[i] <= '0;
                  end
                  step_ff  <= '0;
                  state_ff <= G_DIV;
               end
               G_DIV: begin
                  for (int i = 0; i < LANES; i++) begin
                     lane_q_ff[i] <= lane_q_in[i];
                     lane_r_ff[i] <= lane_r_in[i];
                  end
                  step_ff <= step_ff + 3'd1;
                  if (step_ff == 3'(DIM_W - 1)) begin
                     cx_ff    <= POS_W'(lane_q_in[0]);
                     cy_ff    <= POS_W'(lane_q_in[1]);
                     cz_ff    <= POS_W'(lane_q_in[2]);
                     rx_ff    <= lane_r_in[0];
                     ry_ff    <= lane_r_in[1];
                     rz_ff    <= lane_r_in[2];
                     nx_ff    <= lane_q_in[3];
                     ny_ff    <= lane_q_in[4];
                     nz_ff    <= lane_q_in[5];
                     state_ff <= G_VOL1;
                  end
               end
               G_VOL1: begin
                  vol_ff   <= VOL_W'(merge_x_ff) * VOL_W'(merge_y_ff);
                  nynz_ff  <= ny_ff * nz_ff;
                  state_ff <= G_VOL2;
               end
               G_VOL2: begin
                  vol_ff   <= VOL_W'(vol_ff * merge_z_ff);
                  state_ff <= G_RUN;
               end
               G_RUN: begin
                  if (advance) begin
                     if (z_wrap) begin
                        pos_z_ff <= '0;
                        rz_ff    <= '0;
                        cz_ff    <= '0;
                        if (y_wrap) begin
                           pos_y_ff <= '0;
                           ry_ff    <= '0;
                           cy_ff    <= '0;
                           if (x_wrap) begin
                              pos_x_ff <= '0;
                              rx_ff    <= '0;
                              cx_ff    <= '0;
                           end else begin
                              pos_x_ff <= pos_x_ff + POS_W'(1);
                              if (x_cell) begin
                                 rx_ff <= '0;
                                 cx_ff <= cx_ff + POS_W'(1);
                              end else begin
                                 rx_ff <= rx_ff + POS_W'(1);
                              end
                           end
                        end else begin
                           pos_y_ff <= pos_y_ff + POS_W'(1);
                           if (y_cell) begin
                              ry_ff <= '0;
                              cy_ff <= cy_ff + POS_W'(1);
                           end else begin
                              ry_ff <= ry_ff + POS_W'(1);
                           end
                        end
                     end else begin
                        pos_z_ff <= pos_z_ff + POS_W'(1);
                        if (z_cell) begin
                           rz_ff <= '0;
                           cz_ff <= cz_ff + POS_W'(1);
                        end else begin
                           rz_ff <= rz_ff + POS_W'(1);
                        end
                     end
                  end
               end
               default: state_ff <= G_LOAD;
            endcase
         end
      end
   end

   logic [POS_W+DIM_W-1:0]     cy_nz;
   logic [POS_W+2*DIM_W-1:0]   cx_nynz;
   logic [POS_W+2*DIM_W:0]     index_full;
   logic [POS_W+DIM_W:0]       addr_full;

   assign cy_nz      = cy_ff * nz_ff;
   assign cx_nynz    = cx_ff * nynz_ff;
   assign addr_full  = {1'b0, cy_nz} + (POS_W + DIM_W + 1)'(cz_ff);
   assign index_full = {1'b0, cx_nynz} + (POS_W + 2 * DIM_W + 1)'(cy_nz)
                       + (POS_W + 2 * DIM_W + 1)'(cz_ff);

   always_comb begin
      geom.ready     = (state_ff == G_RUN) && !csr_we;
      geom.in_box    = ({1'b0, cx_ff} < nx_ff) && ({1'b0, cy_ff} < ny_ff)
                       && ({1'b0, cz_ff} < nz_ff);
      geom.first     = (rx_ff == '0) && (ry_ff == '0) && (rz_ff == '0);
      geom.last      = x_cell && y_cell && z_cell;
      geom.last_cell = (({1'b0, cx_ff} + DIM_W'(1)) == nx_ff)
                       && (({1'b0, cy_ff} + DIM_W'(1)) == ny_ff)
                       && (({1'b0, cz_ff} + DIM_W'(1)) == nz_ff);
      geom.addr      = addr_full[SLAB_AW-1:0];
      geom.index     = index_full[INDEX_W-1:0];
      geom.vol       = vol_ff;
   end

endmodule

@@ rtl/core/vba_div.sv @@
`timescale 1ns / 1ps

module vba_div
   import vba_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [SUM_W-1:0]           sum,
   input  logic [VOL_W-1:0]           vol,
   output logic                       busy,
   output logic signed [SAMPLE_W-1:0] result
);

   localparam int CNT_W = $clog2(SUM_W);

   typedef enum logic [1:0] {D_IDLE, D_DIV, D_FIX} state_type;

   state_type            state_ff;
   logic                 neg_ff;
   logic [SUM_W-1:0]     quo_ff;
   logic [VOL_W-2:0]     rem_ff;
   logic [VOL_W-1:0]     vol_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [SAMPLE_W-1:0]  result_ff;

   logic [VOL_W-1:0]     trial;
   logic                 ge;
   logic [SUM_W-1:0]     neg_quo;
   logic                 pos_ovf, neg_ovf;

   assign trial   = {rem_ff, quo_ff[SUM_W-1]};
   assign ge      = trial >= vol_ff;
   assign neg_quo = -quo_ff;
   assign pos_ovf = |quo_ff[SUM_W-1:SAMPLE_W-1];
   assign neg_ovf = (|quo_ff[SUM_W-1:SAMPLE_W])
                    || (quo_ff[SAMPLE_W-1] && (|quo_ff[SAMPLE_W-2:0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         unique case (state_ff)
            D_IDLE: begin
               if (start) begin
                  // Divide the magnitude; the sign is put back at the end.
                  neg_ff   <= sum[SUM_W-1];
                  quo_ff   <= sum[SUM_W-1] ? -sum : sum;
                  rem_ff   <= '0;
                  vol_ff   <= vol;
                  cnt_ff   <= '0;
                  state_ff <= D_DIV;
               end
            end
            D_DIV: begin
               rem_ff <= ge ? (VOL_W - 1)'(trial - vol_ff) : (VOL_W - 1)'(trial);
               quo_ff <= {quo_ff[SUM_W-2:0], ge};
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(SUM_W - 1)) begin
                  state_ff <= D_FIX;
               end
            end
            D_FIX: begin
               if (neg_ff) begin
                  result_ff <= neg_ovf ? {1'b1, {(SAMPLE_W - 1){1'b0}}}
                                       : neg_quo[SAMPLE_W-1:0];
               end else begin
                  result_ff <= pos_ovf ? {1'b0, {(SAMPLE_W - 1){1'b1}}}
                                       : quo_ff[SAMPLE_W-1:0];
               end
               state_ff <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign busy   = (state_ff != D_IDLE);
   assign result = result_ff;

endmodule

@@ rtl/core/volume_block_average_unit.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Payload                                   Handshake
// req_ch   in   fine_sample (32, signed Q16.16)           valid/ready
// rsp_ch   out  coarse_value (32), coarse_index (18),     valid/ready
//               last_cell (1)
// csr_*    in   csr_index (3), csr_wdata (7)              csr_we, no wait
//
// A sample that closes no box makes a slab RAM read, then a write back.
// A sample that closes a box also waits for the bit-serial divider (one quotient
// bit per cycle over the 50-bit sum) and its sign fix-up.
// After reset and after every csr write, ready stays low while the coarse
// geometry is recomputed; the slab RAM has no clearing pass.
// A finished result waits in the output register; the next sample is taken
// meanwhile and stalls only if it closes another box before rsp_ch drains.

module volume_block_average_unit
   import vba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   vba_req_if.sink              req_ch,
   vba_rsp_if.source            rsp_ch
);

   typedef enum logic [1:0] {T_IDLE, T_RMW, T_DIV} state_type;

   state_type                  state_ff;
   geom_type                   geom;
   logic                       accept;

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       in_box_ff, first_ff, last_ff, last_cell_ff;
   logic [SLAB_AW-1:0]         addr_ff;
   logic [INDEX_W-1:0]         index_ff;
   logic [VOL_W-1:0]           vol_ff;

   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_value_ff;
   logic [INDEX_W-1:0]         rsp_index_ff;
   logic                       rsp_last_ff;

   logic [SUM_W-1:0]           rd_data;
   logic [SUM_W-1:0]           sample_ext;
   logic [SUM_W-1:0]           sum_in;
   logic                       wr_en;
   logic                       div_start, div_busy;
   logic signed [SAMPLE_W-1:0] div_result;
   logic                       rsp_load;

   assign req_ch.ready = (state_ff == T_IDLE) && geom.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   vba_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (accept),
      .geom      (geom)
   );

   // The first sample of a box overwrites the entry, so stale contents never matter.
   assign sample_ext = {{(SUM_W - SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};
   assign sum_in     = first_ff ? sample_ext : rd_data + sample_ext;
   assign wr_en      = (state_ff == T_RMW) && in_box_ff;
   assign div_start  = wr_en && last_ff;

   vba_ram #(
      .WIDTH (SUM_W),
      .DEPTH (SLAB_DEPTH)
   ) u_slab (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (sum_in),
      .rd_addr (geom.addr),
      .rd_data (rd_data)
   );

   vba_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .sum    (sum_in),
      .vol    (vol_ff),
      .busy   (div_busy),
      .result (div_result)
   );

   assign rsp_load = (state_ff == T_DIV) && !div_busy
                     && (!rsp_valid_ff || rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            T_IDLE: begin
               if (accept) begin
                  sample_ff    <= req_ch.fine_sample;
                  in_box_ff    <= geom.in_box;
                  first_ff     <= geom.first;
                  last_ff      <= geom.last;
                  last_cell_ff <= geom.last_cell;
                  addr_ff      <= geom.addr;
                  index_ff     <= geom.index;
                  vol_ff       <= geom.vol;
                  state_ff     <= T_RMW;
               end
            end
            T_RMW: begin
               state_ff <= div_start ? T_DIV : T_IDLE;
            end
            T_DIV: begin
               if (rsp_load) begin
                  state_ff <= T_IDLE;
               end
            end
            default: state_ff <= T_IDLE;
         endcase

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_value_ff <= div_result;
            rsp_index_ff <= index_ff;
            rsp_last_ff  <= last_cell_ff;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.coarse_value = rsp_value_ff;
   assign rsp_ch.coarse_index = rsp_index_ff;
   assign rsp_ch.last_cell    = rsp_last_ff;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import vba_pkg::*;

   localparam int     CYCLE_LIMIT   = 1000000;
   localparam int     SETTLE_CYCLES = 80;
   localparam int     RANDOM_ITEMS  = 1300;
   localparam longint VALUE_MAX     = (longint'(1) <<< 31) - 1;
   localparam longint VALUE_MIN     = -(longint'(1) <<< 31);

   typedef struct {
      logic signed [SAMPLE_W-1:0] value;
      logic [INDEX_W-1:0]         index;
      logic                       last;
   } coarse_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_wdata;

   vba_req_if req_ch ();
   vba_rsp_if rsp_ch ();

   volume_block_average_unit dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the geometry registers, indexed by register number.
   logic [DIM_W-1:0]        reg_shadow [0:5];
   logic signed [SUM_W-1:0] slab_box_sum [0:SLAB_DEPTH-1];
   int unsigned             at_x = 0, at_y = 0, at_z = 0;

   logic signed [SAMPLE_W-1:0] fine_samples_todo [$];
   coarse_result_type          coarse_results_due [$];
   coarse_result_type          due_result;
   int unsigned                samples_queued   = 0;
   int unsigned                samples_accepted = 0;
   int unsigned                mismatch_count   = 0;
   int unsigned                cycle_count      = 0;
   logic                       no_gaps          = 1'b0;

   function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   function automatic int unsigned grid_points();
      return clamp_dim(reg_shadow[CSR_FINE_X]) * clamp_dim(reg_shadow[CSR_FINE_Y]) *
             clamp_dim(reg_shadow[CSR_FINE_Z]);
   endfunction

   // Folds one fine sample into its box sum and, when the box is complete,
   // queues the average that the block has to return.
   task automatic accumulate_fine_sample(input logic signed [SAMPLE_W-1:0] fine);
      int unsigned             fx, fy, fz, mx, my, mz, nx, ny, nz;
      int unsigned             cx, cy, cz, rx, ry, rz, addr;
      logic signed [SUM_W-1:0] box_sum;
      longint                  box_vol, avg;
      coarse_result_type       result;
      fx = clamp_dim(reg_shadow[CSR_FINE_X]);
      fy = clamp_dim(reg_shadow[CSR_FINE_Y]);
      fz = clamp_dim(reg_shadow[CSR_FINE_Z]);
      mx = clamp_dim(reg_shadow[CSR_MERGE_X]);
      my = clamp_dim(reg_shadow[CSR_MERGE_Y]);
      mz = clamp_dim(reg_shadow[CSR_MERGE_Z]);
      nx = fx / mx;
      ny = fy / my;
      nz = fz / mz;
      cx = at_x / mx;
      cy = at_y / my;
      cz = at_z / mz;
      rx = at_x % mx;
      ry = at_y % my;
      rz = at_z % mz;
      if (cx < nx && cy < ny && cz < nz) begin
         addr = (cy * nz + cz) % SLAB_DEPTH;
         if (rx == 0 && ry == 0 && rz == 0) begin
            box_sum = fine;
         end else begin
            box_sum = slab_box_sum[addr] + fine;
         end
         slab_box_sum[addr] = box_sum;
         if (rx == mx - 1 && ry == my - 1 && rz == mz - 1) begin
            box_vol = longint'(mx) * longint'(my) * longint'(mz);
            avg = longint'(box_sum) / box_vol;
            if (avg > VALUE_MAX) avg = VALUE_MAX;
            if (avg < VALUE_MIN) avg = VALUE_MIN;
            result.value = avg[SAMPLE_W-1:0];
            result.index = INDEX_W'((cx * ny + cy) * nz + cz);
            result.last  = (cx == nx - 1) && (cy == ny - 1) && (cz == nz - 1);
            coarse_results_due = {coarse_results_due, result};
         end
      end
      if (at_z + 1 >= fz) begin
         at_z = 0;
         if (at_y + 1 >= fy) begin
            at_y = 0;
            if (at_x + 1 >= fx) at_x = 0;
            else at_x++;
         end else begin
            at_y++;
         end
      end else begin
         at_z++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            accumulate_fine_sample(req_ch.fine_sample);
            samples_accepted++;
         end
         if (fine_samples_todo.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 10)) begin
            req_ch.valid       <= 1'b1;
            req_ch.fine_sample <= fine_samples_todo.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   task automatic flag_mismatch(input string what, input longint want, input longint got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (coarse_results_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, expected none, got index %0d value %0d",
                        $time, rsp_ch.coarse_index, rsp_ch.coarse_value);
            end else begin
               due_result = coarse_results_due.pop_front();
               if (rsp_ch.coarse_value !== due_result.value)
                  flag_mismatch("coarse_value", due_result.value, rsp_ch.coarse_value);
               if (rsp_ch.coarse_index !== due_result.index)
                  flag_mismatch("coarse_index", due_result.index, rsp_ch.coarse_index);
               if (rsp_ch.last_cell !== due_result.last)
                  flag_mismatch("last_cell", due_result.last, rsp_ch.last_cell);
            end
         end
         rsp_ch.ready <= no_gaps || $urandom_range(0, 99) >= 10;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count,
                  coarse_results_due.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= DIM_W'(val);
      reg_shadow[idx] = DIM_W'(val);
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_grid(input int unsigned fx, fy, fz, mx, my, mz);
      write_reg(CSR_FINE_X, fx);
      write_reg(CSR_FINE_Y, fy);
      write_reg(CSR_FINE_Z, fz);
      write_reg(CSR_MERGE_X, mx);
      write_reg(CSR_MERGE_Y, my);
      write_reg(CSR_MERGE_Z, mz);
      end_writes();
   endtask

   task automatic queue_sample(input logic signed [SAMPLE_W-1:0] v);
      fine_samples_todo = {fine_samples_todo, v};
      samples_queued++;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] draw_sample();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return $urandom_range(0, 8) - 4;
         default: return $urandom;
      endcase
   endfunction

   // Waits until every queued sample has been taken and every result has
   // come back, then lets the last non-emitting samples leave the pipeline.
   task automatic settle();
      while (samples_accepted != samples_queued || coarse_results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register values for a size; 0 and values above the maximum stand in
   // for 1 and the maximum now and then.
   function automatic logic [DIM_W-1:0] encode_dim(int unsigned d);
      if (d == 1 && $urandom_range(0, 3) == 0) return '0;
      if (d == MAX_DIM && $urandom_range(0, 1) == 0)
         return DIM_W'($urandom_range(MAX_DIM + 1, (1 << DIM_W) - 1));
      return DIM_W'(d);
   endfunction

   initial begin
      int unsigned fine_dim [3];
      int unsigned merge_dim [3];
      int unsigned random_items;
      int unsigned phase;
      int unsigned grids;
      int unsigned axis;
      logic        big;
      csr_we       = 1'b0;
      csr_index    = CSR_FINE_X;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.fine_sample = '0;
      rsp_ch.ready = 1'b0;
      for (int i = 0; i < 6; i++) reg_shadow[i] = DIM_W'(1);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: every sample is a whole one-cell grid.
      queue_sample(32'sh7FFF_FFFF);
      queue_sample(32'sh8000_0000);
      settle();

      // Zero registers act as 1; the z = 2 column lies outside the box and
      // the negative sum checks truncation toward zero.
      program_grid(0, 2, 3, 0, 2, 2);
      queue_sample(32'sh8000_0000);
      queue_sample(-3);
      queue_sample(5);
      queue_sample(32'sh8000_0000);
      queue_sample(-2);
      queue_sample(9);
      settle();

      // Merge wider than the grid: nothing comes out, positions still wrap.
      program_grid(1, 1, 2, 1, 1, 3);
      repeat (4) queue_sample(draw_sample());
      settle();

      // Shrink z under the current position in the middle of a grid. The
      // full grid first makes sure every box sum the rest touches exists.
      program_grid(1, 2, 4, 1, 1, 2);
      repeat (8) queue_sample(draw_sample());
      settle();
      repeat (3) queue_sample(draw_sample());
      settle();
      write_reg(CSR_FINE_Z, 2);
      end_writes();
      repeat (3) queue_sample(draw_sample());
      settle();

      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         big  = ($urandom_range(0, 9) == 0);
         axis = $urandom_range(0, 2);
         for (int a = 0; a < 3; a++) begin
            if (big) fine_dim[a] = (a == axis) ? MAX_DIM : $urandom_range(1, 2);
            else fine_dim[a] = $urandom_range(1, 6);
            case ($urandom_range(0, 9))
               0: merge_dim[a] = (fine_dim[a] < MAX_DIM) ? fine_dim[a] + 1 : MAX_DIM;
               1, 2: merge_dim[a] = 1;
               default: merge_dim[a] = $urandom_range(1, fine_dim[a]);
            endcase
            if (big && a == axis) begin
               case ($urandom_range(0, 4))
                  0: merge_dim[a] = 1;
                  1: merge_dim[a] = 2;
                  2: merge_dim[a] = 8;
                  3: merge_dim[a] = 32;
                  default: merge_dim[a] = MAX_DIM;
               endcase
            end
         end
         // A stretch of phases runs with both sides at full rate.
         no_gaps = (phase >= 5 && phase < 12);
         program_grid(encode_dim(fine_dim[0]), encode_dim(fine_dim[1]),
                      encode_dim(fine_dim[2]), encode_dim(merge_dim[0]),
                      encode_dim(merge_dim[1]), encode_dim(merge_dim[2]));
         grids = big ? 1 : $urandom_range(1, 3);
         repeat (grids * grid_points()) queue_sample(draw_sample());
         random_items += grids * grid_points();
         settle();
         phase++;
      end

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
